FILE: hdl/box_filter_3x3_mean_macros.svh
// Assertion macros used by the box filter top level
`ifndef BOX_FILTER_3X3_MEAN_MACROS_SVH
`define BOX_FILTER_3X3_MEAN_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BF3M_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box filter assertion failed");

// Next-cycle implication, checked outside reset
`define BF3M_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box filter assertion failed");

`endif

FILE: hdl/bf3m_pkg.sv
// Types and constants of the 3x3 box filter
package bf3m_pkg;

    localparam int PIX_W      = 16;
    localparam int SIDE_W     = 10;
    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COLSUM_W   = PIX_W + 2;
    localparam int SUM_W      = PIX_W + 4;
    localparam int RECIP_SH   = 23;
    localparam int PROD_W     = 2 * SUM_W;

    // ceil(2^23 / 9): exact floor division for any 20-bit sum
    localparam logic [SUM_W-1:0] RECIP9 = SUM_W'(932068);

    localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(1);
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(DEPTH - 2);
    localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(1022);

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } pos_flags_t;

endpackage

FILE: hdl/box_filter_3x3_mean.sv
// Top level of the streaming 3x3 box filter (mean)
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tdata[15:0] pixel
//  m_*      | out | m_tvalid/m_tready | tdata[15:0] mean, tlast row_end,
//           |     |                   | tuser[0] frame_end
//  cfg_*    | in  | cfg_valid/cfg_ready | cfg_data[9:0] out_side
//
// One pixel per cycle unless m_tready stalls; after its pixel is taken, a result passes
// the line-memory read register, the sum register and the divide-by-nine result register.
// Reset clears the position counters, the window and all valid flags;
// out_side returns to 1022. The line memories have no reset.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
// A cfg_data write restarts the frame at padded row 0, column 0.
module box_filter_3x3_mean
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] mean
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data   // [9:0] out_side
);
    import bf3m_pkg::*;
    `include "box_filter_3x3_mean_macros.svh"

    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_clamped;
    logic [SIDE_W-1:0] last_idx;
    logic [SIDE_W-1:0] col_reg;
    logic [SIDE_W-1:0] row_reg;
    logic [SIDE_W-1:0] col_next;
    logic [SIDE_W-1:0] row_next;
    logic              adv;
    logic              acc;
    logic              cfg_wr;
    pos_flags_t        flags_now;

    logic              v0_reg;
    logic [PIX_W-1:0]  pix0_reg;
    logic [ADDR_W-1:0] addr0_reg;
    pos_flags_t        flags0_reg;
    logic [PIX_W-1:0]  mid0;
    logic [PIX_W-1:0]  top0;

    logic              sum_valid;
    pos_flags_t        sum_flags;
    logic [SUM_W-1:0]  sum;
    logic              mean_row_end;
    logic              mean_frame_end;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign acc       = s_tvalid && s_tready;

    always_comb
    begin
        side_clamped = side_reg;
        if (side_reg < SIDE_MIN)
        begin
            side_clamped = SIDE_MIN;
        end
        else if (side_reg > SIDE_MAX)
        begin
            side_clamped = SIDE_MAX;
        end
    end

    assign last_idx = side_clamped + SIDE_W'(1);

    always_comb
    begin
        flags_now.emit      = (row_reg >= SIDE_W'(2)) && (col_reg >= SIDE_W'(2));
        flags_now.row_end   = (col_reg == last_idx);
        flags_now.frame_end = (col_reg == last_idx) && (row_reg == last_idx);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (col_reg == last_idx)
            begin
                col_next = '0;
                row_next = (row_reg == last_idx) ? '0 : row_reg + SIDE_W'(1);
            end
            else
            begin
                col_next = col_reg + SIDE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RST;
            col_reg  <= '0;
            row_reg  <= '0;
            v0_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                side_reg <= cfg_data;
                col_reg  <= '0;
                row_reg  <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv)
            begin
                v0_reg <= acc;
            end
        end
    end

    // hold the pixel beside its line-memory read data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix0_reg   <= s_tdata;
            addr0_reg  <= col_reg[ADDR_W-1:0];
            flags0_reg <= flags_now;
        end
    end

    bf3m_line_buf u_line_buf
    (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (col_reg[ADDR_W-1:0]),
        .mid     (mid0),
        .top     (top0),
        .wr_en   (v0_reg && adv),
        .wr_addr (addr0_reg),
        .wr_bot  (pix0_reg),
        .wr_mid  (mid0)
    );

    bf3m_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v0_reg),
        .in_flags  (flags0_reg),
        .top       (top0),
        .mid       (mid0),
        .bot       (pix0_reg),
        .sum_valid (sum_valid),
        .sum_flags (sum_flags),
        .sum       (sum)
    );

    bf3m_div9 u_div9
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sum_valid),
        .in_flags  (sum_flags),
        .sum       (sum),
        .out_valid (m_tvalid),
        .mean      (m_tdata),
        .row_end   (mean_row_end),
        .frame_end (mean_frame_end)
    );

    assign m_tlast    = mean_row_end;
    assign m_tuser[0] = mean_frame_end;

    `BF3M_ASSERT_IMPL(a_col_in_range, clk, rst_n, 1'b1, col_reg <= last_idx && row_reg <= last_idx)
    `BF3M_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_wr, col_reg == '0 && row_reg == '0)
    `BF3M_ASSERT_IMPL(a_frame_end_last, clk, rst_n, m_tvalid && m_tuser[0], m_tlast)
    `BF3M_ASSERT_NEXT(a_frame_wrap, clk, rst_n, acc && flags_now.frame_end, col_reg == '0 && row_reg == '0)

endmodule

FILE: hdl/bf3m_line_buf.sv
// Two line memories holding the previous two padded rows
module bf3m_line_buf
(
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [bf3m_pkg::ADDR_W-1:0]   rd_addr,
    output logic [bf3m_pkg::PIX_W-1:0]    mid,
    output logic [bf3m_pkg::PIX_W-1:0]    top,
    input  logic                          wr_en,
    input  logic [bf3m_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [bf3m_pkg::PIX_W-1:0]    wr_bot,
    input  logic [bf3m_pkg::PIX_W-1:0]    wr_mid
);
    import bf3m_pkg::*;

    logic [PIX_W-1:0] line_a_mem [DEPTH];
    logic [PIX_W-1:0] line_b_mem [DEPTH];
    logic [PIX_W-1:0] mid_reg;
    logic [PIX_W-1:0] top_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_a_mem[wr_addr] <= wr_bot;
            line_b_mem[wr_addr] <= wr_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_reg <= line_a_mem[rd_addr];
            top_reg <= line_b_mem[rd_addr];
        end
    end

    assign mid = mid_reg;
    assign top = top_reg;

endmodule

FILE: hdl/bf3m_window.sv
// Column sums of the 3x3 window and the nine-pixel sum register
module bf3m_window
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  bf3m_pkg::pos_flags_t          in_flags,
    input  logic [bf3m_pkg::PIX_W-1:0]    top,
    input  logic [bf3m_pkg::PIX_W-1:0]    mid,
    input  logic [bf3m_pkg::PIX_W-1:0]    bot,
    output logic                          sum_valid,
    output bf3m_pkg::pos_flags_t          sum_flags,
    output logic [bf3m_pkg::SUM_W-1:0]    sum
);
    import bf3m_pkg::*;

    logic [COLSUM_W-1:0] cs_now;
    logic [COLSUM_W-1:0] cs0_reg;
    logic [COLSUM_W-1:0] cs1_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    sum_reg;
    logic                valid_reg;
    pos_flags_t          flags_reg;

    assign cs_now   = COLSUM_W'(top) + COLSUM_W'(mid) + COLSUM_W'(bot);
    assign sum_next = SUM_W'(cs0_reg) + SUM_W'(cs1_reg) + SUM_W'(cs_now);

    // shift the window one column on every pixel, border pixels included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs0_reg   <= '0;
            cs1_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid && in_flags.emit;
            if (in_valid)
            begin
                cs0_reg <= cs1_reg;
                cs1_reg <= cs_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg   <= sum_next;
            flags_reg <= in_flags;
        end
    end

    assign sum_valid = valid_reg;
    assign sum_flags = flags_reg;
    assign sum       = sum_reg;

endmodule

FILE: hdl/bf3m_div9.sv
// Divide the window sum by nine and hold the result register
module bf3m_div9
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  bf3m_pkg::pos_flags_t          in_flags,
    input  logic [bf3m_pkg::SUM_W-1:0]    sum,
    output logic                          out_valid,
    output logic [bf3m_pkg::PIX_W-1:0]    mean,
    output logic                          row_end,
    output logic                          frame_end
);
    import bf3m_pkg::*;

    logic [PROD_W-1:0] prod;
    logic              valid_reg;
    logic [PIX_W-1:0]  mean_reg;
    logic              row_end_reg;
    logic              frame_end_reg;

    // multiply by the rounded-up reciprocal; the shift truncates
    assign prod = PROD_W'(sum) * PROD_W'(RECIP9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mean_reg      <= prod[RECIP_SH +: PIX_W];
            row_end_reg   <= in_flags.row_end;
            frame_end_reg <= in_flags.frame_end;
        end
    end

    assign out_valid = valid_reg;
    assign mean      = mean_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: sim/box_mean_checker.sv
// Checker for the 3x3 box filter: predicts every window mean and compares the output stream
module box_mean_checker
    import bf3m_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // [15:0] pixel
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [PIX_W-1:0]  m_tdata,   // [15:0] mean
    input  logic              m_tlast,
    input  logic [0:0]        m_tuser,   // [0] frame_end
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [SIDE_W-1:0] cfg_data,  // [9:0] out_side
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_PIXELS = 9;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             row_end;
        logic             frame_end;
    } window_mean_t;

    logic [SIDE_W-1:0] side_reg;
    logic [PIX_W-1:0]  row_above [DEPTH];
    logic [PIX_W-1:0]  row_above2 [DEPTH];
    logic [PIX_W-1:0]  window_cols [6];
    int unsigned       col_pos;
    int unsigned       row_pos;
    window_mean_t      mean_queue [$];

    function automatic int unsigned padded_side(input logic [SIDE_W-1:0] n);
        logic [SIDE_W-1:0] used;
        used = n;
        if (used < SIDE_MIN)
            used = SIDE_MIN;
        if (used > SIDE_MAX)
            used = SIDE_MAX;
        return int'(used) + 2;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        errors++;
        $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
    endtask

    // Shift one pixel into the window and queue the mean it completes, if any
    task automatic take_pixel(input logic [PIX_W-1:0] px);
        int unsigned      p;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [SUM_W-1:0] sum;
        window_mean_t     item;
        p = padded_side(side_reg);
        c = (col_pos >= p) ? 0 : col_pos;
        r = (row_pos >= p) ? 0 : row_pos;
        mid = row_above[c];
        top = row_above2[c];
        if (r >= 2 && c >= 2)
        begin
            sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(px);
            for (int i = 0; i < 6; i++)
                sum += SUM_W'(window_cols[i]);
            item.mean      = PIX_W'(sum / WINDOW_PIXELS);
            item.row_end   = (c == p - 1);
            item.frame_end = (c == p - 1) && (r == p - 1);
            mean_queue.push_back(item);
        end
        for (int i = 0; i < 3; i++)
            window_cols[i] = window_cols[i + 3];
        window_cols[3] = top;
        window_cols[4] = mid;
        window_cols[5] = px;
        row_above2[c] = mid;
        row_above[c]  = px;
        if (c == p - 1)
        begin
            col_pos = 0;
            row_pos = (r == p - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_mean_t want;
        if (!rst_n)
        begin
            side_reg = SIDE_RST;
            for (int i = 0; i < DEPTH; i++)
            begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            for (int i = 0; i < 6; i++)
                window_cols[i] = '0;
            col_pos = 0;
            row_pos = 0;
            mean_queue.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (mean_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected output: expected none, actual mean %0h",
                             $time, m_tdata);
                end
                else
                begin
                    want = mean_queue.pop_front();
                    if (m_tdata !== want.mean)
                        flag_mismatch("mean", want.mean, m_tdata);
                    if (m_tlast !== want.row_end)
                        flag_mismatch("row_end", want.row_end, m_tlast);
                    if (m_tuser[0] !== want.frame_end)
                        flag_mismatch("frame_end", want.frame_end, m_tuser[0]);
                end
            end
            // a register write restarts the frame
            if (cfg_valid && cfg_ready)
            begin
                side_reg = cfg_data;
                col_pos  = 0;
                row_pos  = 0;
            end
            if (s_tvalid && s_tready)
                take_pixel(s_tdata);
            pending = mean_queue.size();
        end
    end

endmodule

FILE: sim/box_filter_3x3_mean_tb.sv
// Testbench top for the 3x3 box filter: stimulus, clock, reset and verdict
module box_filter_3x3_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bf3m_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_ITEMS = 600;
    localparam int PROBE_RUN    = 200;
    localparam int CFG_SETTLE   = 8;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FILL_RANDOM  = -1;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [PIX_W-1:0]  m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIDE_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int cycles = 0;
    bit steady = 1'b0;

    box_filter_3x3_mean DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    box_mean_checker mean_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("box_filter_3x3_mean: mismatch");
            $finish;
        end
    end

    // stall the output side at random, except during the steady stretch
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    function automatic int unsigned padded_of(input int unsigned n);
        int unsigned used;
        used = (n < SIDE_MIN) ? SIDE_MIN : n;
        if (used > SIDE_MAX)
            used = SIDE_MAX;
        return used + 2;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
    endtask

    // Send count pixels, all equal to fill, or random when fill is negative
    task automatic send_run(input int unsigned count, input int fill);
        for (int unsigned i = 0; i < count; i++)
            send_pixel((fill < 0) ? rand_pixel() : PIX_W'(fill));
        s_tvalid <= 1'b0;
    endtask

    // Write out_side once every result is out and border pixels have drained
    task automatic write_side(input logic [SIDE_W-1:0] value);
        // let the last pixel's prediction reach the pending count
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned side_val;
        int unsigned p;
        int unsigned n;
        int unsigned sent;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset side: the first padded rows of the largest frame give no result
        send_run(PROBE_RUN, FILL_RANDOM);
        // all ones saturates to the largest side
        write_side('1);
        send_run(PROBE_RUN, FILL_RANDOM);
        // zero is taken as side one; two frames check the wrap
        write_side('0);
        send_run(9, (1 << PIX_W) - 1);
        send_run(9, 0);
        write_side(SIDE_W'(1));
        send_run(9, FILL_RANDOM);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= 200 && sent < 450);
            if ($urandom_range(7) == 0)
                side_val = $urandom_range(13, 24);
            else
                side_val = $urandom_range(0, 12);
            write_side(SIDE_W'(side_val));
            p = padded_of(side_val);
            case ($urandom_range(3))
                0: n = $urandom_range(1, p * p - 1);
                1: n = p * p * $urandom_range(2, 3);
                default: n = p * p;
            endcase
            if (side_val > 12)
                n = p * p;
            send_run(n, FILL_RANDOM);
            sent += n;
        end
        steady = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("box_filter_3x3_mean: match");
        else
            $display("box_filter_3x3_mean: mismatch");
        $finish;
    end

endmodule
